>>> rtl/core/pdi_pkg.sv
// Package for the paren depth indenter: shared constants, state enum and
// the command and status structs between controller and datapath.
// No dependencies.
package pdi_pkg;

  // Default indent cap in levels (two spaces per level)
  localparam int unsigned INDENT_CAP_DEF = 31;

  // Character codes
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_SLASH  = 8'h2F;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_SQUOTE = 8'h27;
  localparam logic [7:0] CHR_DQUOTE = 8'h22;
  localparam logic [7:0] CHR_NL     = 8'h0A;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_CR     = 8'h0D;

  // Warning codes
  localparam logic [2:0] WARN_NONE      = 3'd0;
  localparam logic [2:0] WARN_NESTED    = 3'd1;
  localparam logic [2:0] WARN_NL_SQUOTE = 3'd2;
  localparam logic [2:0] WARN_NL_DQUOTE = 3'd3;
  localparam logic [2:0] WARN_CLOSE_MIS = 3'd4;
  localparam logic [2:0] WARN_OPEN_MIS  = 3'd5;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NL,
    ST_SPC,
    ST_TAIL
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // input beat taken
    logic emit_nl;    // write a newline beat
    logic emit_spc;   // write a space beat, count down
    logic tail_step;  // run byte handling or end-of-file clear
    logic tail_emit;  // write the tail result beat
    logic last;       // last flag for the beat written
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_eof;
    logic in_ws;
    logic in_nl;
    logic skipping;
    logic skip_nl;
    logic cnt_zero;
    logic cnt_one;
    logic tail_has_result;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/pdi_ctrl.sv
// Controller of the paren depth indenter: sequences newline, indent spaces
// and the tail step of each input beat. Depends on pdi_pkg.
module pdi_ctrl
  import pdi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_eof) begin
            state_d = sts_i.skipping ? ST_NL : ST_TAIL;
          end else if (sts_i.skipping) begin
            if (!sts_i.in_ws || sts_i.in_nl) begin
              state_d = ST_NL;
            end
          end else begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_NL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_nl = 1'b1;
          cmd_o.last    = sts_i.cnt_zero && (sts_i.skip_nl || !sts_i.tail_has_result);
          if (!sts_i.cnt_zero) begin
            state_d = ST_SPC;
          end else begin
            state_d = sts_i.skip_nl ? ST_IDLE : ST_TAIL;
          end
        end
      end
      ST_SPC: begin
        if (sts_i.out_free) begin
          cmd_o.emit_spc = 1'b1;
          cmd_o.last     = sts_i.cnt_one && !sts_i.tail_has_result;
          if (sts_i.cnt_one) begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (!sts_i.tail_has_result) begin
          cmd_o.tail_step = 1'b1;
          state_d         = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.tail_step = 1'b1;
          cmd_o.tail_emit = 1'b1;
          cmd_o.last      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/pdi_datapath.sv
// Datapath of the paren depth indenter: depth, quote and comment flags,
// line count, indent counter and the output register. Depends on pdi_pkg.
module pdi_datapath
  import pdi_pkg::*;
#(
  parameter int unsigned IndentCap = INDENT_CAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_file_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [2:0]  warning_o,
  output logic [15:0] warn_value_o,
  output logic        last_o,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o
);

  localparam int unsigned CntW = $clog2(2 * IndentCap + 1);

  // Text state
  logic signed [15:0] depth_q, depth_d;
  logic               dq_q, dq_d;
  logic               sq_q, sq_d;
  logic               cmt_q, cmt_d;
  logic               skip_q, skip_d;
  logic [7:0]         prior_q, prior_d;
  logic [15:0]        line_q, line_d;

  // Per-beat working registers
  logic [7:0]         byte_q;
  logic               eof_q;
  logic               skip_nl_q, skip_nl_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [7:0]         ob_q, ob_d;
  logic               obv_q, obv_d;
  logic [2:0]         ow_q, ow_d;
  logic [15:0]        owv_q, owv_d;
  logic               olast_q, olast_d;

  logic               in_ws, in_nl;
  logic               depth_pos, depth_nz;
  logic [15:0]        line_inc;
  logic [CntW-1:0]    indent_cnt;
  logic [2:0]         tail_w;
  logic               emit_any;

  assign in_nl = (in_byte_i == CHR_NL);
  assign in_ws = (in_byte_i == CHR_SPACE) ||
                 ((in_byte_i >= CHR_TAB) && (in_byte_i <= CHR_CR));

  assign depth_nz  = (depth_q != 16'sd0);
  assign depth_pos = depth_nz && !depth_q[15];
  assign line_inc  = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;

  // Spaces for the indent: two per level, capped, none at negative depth
  always_comb begin
    if (!depth_pos) begin
      indent_cnt = '0;
    end else if (depth_q > $signed(16'(IndentCap))) begin
      indent_cnt = CntW'(2 * IndentCap);
    end else begin
      indent_cnt = {depth_q[CntW-2:0], 1'b0};
    end
  end

  // Status
  always_comb begin
    sts_o.in_eof   = end_of_file_i;
    sts_o.in_ws    = in_ws;
    sts_o.in_nl    = in_nl;
    sts_o.skipping = skip_q;
    sts_o.skip_nl  = skip_nl_q;
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.cnt_one  = (cnt_q == CntW'(1));
    sts_o.out_free = !out_valid_q || !out_stall_i;
    if (eof_q) begin
      sts_o.tail_has_result = depth_nz;
    end else begin
      sts_o.tail_has_result = !((byte_q == CHR_RPAREN) && depth_q[15]) &&
                              !((byte_q == CHR_NL) && !sq_q && !dq_q);
    end
  end

  // State update: load, indent countdown and tail step
  always_comb begin
    depth_d   = depth_q;
    dq_d      = dq_q;
    sq_d      = sq_q;
    cmt_d     = cmt_q;
    skip_d    = skip_q;
    prior_d   = prior_q;
    line_d    = line_q;
    skip_nl_d = skip_nl_q;
    cnt_d     = cnt_q;
    tail_w    = WARN_NONE;

    if (cmd_i.load) begin
      skip_nl_d = !end_of_file_i && skip_q && in_nl;
      cnt_d     = (!end_of_file_i && skip_q && in_ws) ? '0 : indent_cnt;
      if (!end_of_file_i && skip_q) begin
        if (in_ws) begin
          if (in_nl) begin
            line_d = line_inc;
          end
        end else begin
          // Leaving the whitespace run: byte is its own prior byte
          skip_d  = 1'b0;
          prior_d = in_byte_i;
        end
      end
    end

    if (cmd_i.emit_spc) begin
      cnt_d = cnt_q - CntW'(1);
    end

    if (cmd_i.tail_step) begin
      if (eof_q) begin
        depth_d = '0;
        dq_d    = 1'b0;
        sq_d    = 1'b0;
        cmt_d   = 1'b0;
        skip_d  = 1'b0;
        prior_d = '0;
        line_d  = '0;
      end else begin
        prior_d = byte_q;
        case (byte_q)
          CHR_SLASH: begin
            if (prior_q == CHR_STAR) begin
              if (cmt_q) cmt_d = 1'b0;
              else       tail_w = WARN_NESTED;
            end
          end
          CHR_STAR: begin
            if (prior_q == CHR_SLASH) begin
              if (!cmt_q) cmt_d = 1'b1;
              else        tail_w = WARN_NESTED;
            end
          end
          CHR_LPAREN: begin
            if (!dq_q && !sq_q && (depth_q != 16'sh7FFF)) depth_d = depth_q + 16'sd1;
          end
          CHR_RPAREN: begin
            if (!depth_q[15] && !dq_q && !sq_q) depth_d = depth_q - 16'sd1;
          end
          CHR_NL: begin
            line_d = line_inc;
            skip_d = 1'b1;
          end
          CHR_DQUOTE: begin
            if (!sq_q && !cmt_q) dq_d = !dq_q;
          end
          CHR_SQUOTE: begin
            if (!dq_q && !cmt_q) sq_d = !sq_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output beat contents
  assign emit_any = cmd_i.emit_nl || cmd_i.emit_spc || cmd_i.tail_emit;

  always_comb begin
    out_valid_d = emit_any ? 1'b1 : (out_valid_q && out_stall_i);
    ob_d        = ob_q;
    obv_d       = obv_q;
    ow_d        = ow_q;
    owv_d       = owv_q;
    olast_d     = olast_q;
    if (emit_any) begin
      olast_d = cmd_i.last;
      ob_d    = '0;
      obv_d   = 1'b0;
      ow_d    = WARN_NONE;
      owv_d   = '0;
      if (cmd_i.emit_nl) begin
        ob_d  = CHR_NL;
        obv_d = 1'b1;
      end else if (cmd_i.emit_spc) begin
        ob_d  = CHR_SPACE;
        obv_d = 1'b1;
      end else if (eof_q) begin
        ow_d  = depth_pos ? WARN_CLOSE_MIS : WARN_OPEN_MIS;
        owv_d = depth_pos ? depth_q : 16'(-depth_q);
      end else if (byte_q == CHR_NL) begin
        ow_d  = sq_q ? WARN_NL_SQUOTE : WARN_NL_DQUOTE;
        owv_d = line_inc;
      end else begin
        ob_d  = byte_q;
        obv_d = 1'b1;
        ow_d  = tail_w;
        owv_d = (tail_w != WARN_NONE) ? line_q : '0;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      dq_q        <= 1'b0;
      sq_q        <= 1'b0;
      cmt_q       <= 1'b0;
      skip_q      <= 1'b0;
      prior_q     <= '0;
      line_q      <= '0;
      skip_nl_q   <= 1'b0;
      cnt_q       <= '0;
      eof_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      dq_q        <= dq_d;
      sq_q        <= sq_d;
      cmt_q       <= cmt_d;
      skip_q      <= skip_d;
      prior_q     <= prior_d;
      line_q      <= line_d;
      skip_nl_q   <= skip_nl_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load) eof_q <= end_of_file_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) byte_q <= in_byte_i;
    ob_q    <= ob_d;
    obv_q   <= obv_d;
    ow_q    <= ow_d;
    owv_q   <= owv_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = ob_q;
  assign byte_valid_o = obv_q;
  assign warning_o    = ow_q;
  assign warn_value_o = owv_q;
  assign last_o       = olast_q;

endmodule

>>> rtl/core/paren_depth_indenter_top.sv
// A result is registered in the output register on its step; a plain byte
// is accepted in ST_IDLE, handled in ST_TAIL, and the block then returns
// to ST_IDLE. A newline run ending adds one newline beat in ST_NL and one
// space beat per indent space in ST_SPC; a swallowed blank stays in ST_IDLE.
// Reset (rst_ni low, asynchronous) clears depth, flags, line count and the
// output valid flag; end of file clears the text state the same way.
// Top level of the paren depth indenter; depends on pdi_pkg, pdi_ctrl and
// pdi_datapath.
module paren_depth_indenter_top
  import pdi_pkg::*;
#(
  parameter int unsigned IndentCap = INDENT_CAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [2:0]  warning_o,
  output logic [15:0] warn_value_o,
  output logic        last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  pdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Text state and output beat register
  pdi_datapath #(
    .IndentCap (IndentCap)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .end_of_file_i (end_of_file_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .warning_o     (warning_o),
    .warn_value_o  (warn_value_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

>>> rtl/core/pdi_checker.sv
// Port-level checks for the paren depth indenter, bound to the top level.
// Depends on pdi_pkg.
module pdi_checker
  import pdi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_file_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        byte_valid_o,
  input logic [2:0]  warning_o,
  input logic [15:0] warn_value_o,
  input logic        last_o
);

  // An end-of-file beat always keeps the block busy for its tail step
  a_eof_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_file_i |=> in_stall_o)
    else $error("end-of-file beat did not hold off input");

  // Beats without a byte carry a zero byte and a warning
  a_nobyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> (out_byte_o == 8'd0) && (warning_o != WARN_NONE))
    else $error("empty beat carries a byte or no warning");

  // Warning value only with a warning
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (warning_o == WARN_NONE) |-> (warn_value_o == 16'd0))
    else $error("warning value without warning");

  // Byte beats carry at most the nested-comment warning
  a_byte_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |->
      (warning_o == WARN_NONE) || (warning_o == WARN_NESTED))
    else $error("byte beat with a non-byte warning");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output beat changed");

endmodule

bind paren_depth_indenter_top pdi_checker u_pdi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .end_of_file_i (end_of_file_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .byte_valid_o  (byte_valid_o),
  .warning_o     (warning_o),
  .warn_value_o  (warn_value_o),
  .last_o        (last_o)
);

>>> tb/paren_depth_indenter_top_test.sv
// Self-checking testbench for paren_depth_indenter_top: drives text beats,
// predicts every output beat and compares them in order of arrival.
// Depends on pdi_pkg and paren_depth_indenter_top.
module paren_depth_indenter_top_test
  import pdi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDENT_LEVELS = int'(INDENT_CAP_DEF);
  localparam int DRAIN_CYCLES  = 200;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;

  // One output beat as the block presents it
  typedef struct packed {
    logic [7:0]  ch;
    logic        ch_valid;
    logic [2:0]  warn;
    logic [15:0] warn_val;
    logic        last;
  } text_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic [2:0]  warning_o;
  logic [15:0] warn_value_o;
  logic        last_o;

  // Shadow text state
  logic signed [15:0] depth_q;
  logic               in_dquote_q;
  logic               in_squote_q;
  logic               in_comment_q;
  logic               skip_blank_q;
  logic [7:0]         prev_byte_q;
  logic [15:0]        line_q;

  text_beat_t expected_beats[$];
  int         mismatch_count = 0;
  int         text_items_sent = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  paren_depth_indenter_top #(
    .IndentCap(INDENT_LEVELS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .warning_o     (warning_o),
    .warn_value_o  (warn_value_o),
    .last_o        (last_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Indent predictor
  // ---------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] b);
    return b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR);
  endfunction

  task automatic clear_text_state();
    depth_q      = '0;
    in_dquote_q  = 1'b0;
    in_squote_q  = 1'b0;
    in_comment_q = 1'b0;
    skip_blank_q = 1'b0;
    prev_byte_q  = '0;
    line_q       = '0;
  endtask

  task automatic push_beat(input logic [7:0] ch, input logic vld, input logic [2:0] w,
                           input logic [15:0] v);
    text_beat_t bt;
    bt.ch       = vld ? ch : 8'h00;
    bt.ch_valid = vld;
    bt.warn     = w;
    bt.warn_val = (w != WARN_NONE) ? v : 16'h0000;
    bt.last     = 1'b0;
    expected_beats.push_back(bt);
  endtask

  task automatic bump_line();
    if (line_q != 16'hFFFF) line_q++;
  endtask

  // Newline plus two spaces per level, capped; no spaces at negative depth
  task automatic push_indent();
    int lv;
    lv = depth_q;
    if (lv > INDENT_LEVELS) lv = INDENT_LEVELS;
    push_beat(CHR_NL, 1'b1, WARN_NONE, '0);
    for (int i = 0; i < lv; i++) begin
      push_beat(CHR_SPACE, 1'b1, WARN_NONE, '0);
      push_beat(CHR_SPACE, 1'b1, WARN_NONE, '0);
    end
  endtask

  // Ordinary byte handling outside the blank-skipping phase
  task automatic track_byte(input logic [7:0] b);
    logic [7:0] p;
    logic [2:0] w;
    p = prev_byte_q;
    w = WARN_NONE;
    prev_byte_q = b;
    case (b)
      CHR_SLASH: begin
        if (p == CHR_STAR) begin
          if (in_comment_q) in_comment_q = 1'b0;
          else w = WARN_NESTED;
        end
      end
      CHR_STAR: begin
        if (p == CHR_SLASH) begin
          if (!in_comment_q) in_comment_q = 1'b1;
          else w = WARN_NESTED;
        end
      end
      CHR_LPAREN: begin
        if (!in_dquote_q && !in_squote_q && depth_q < 16'sd32767) depth_q++;
      end
      CHR_RPAREN: begin
        // stray close at negative depth is dropped
        if (depth_q < 16'sd0) return;
        if (!in_dquote_q && !in_squote_q) depth_q--;
      end
      CHR_NL: begin
        bump_line();
        if (in_squote_q) push_beat(8'h00, 1'b0, WARN_NL_SQUOTE, line_q);
        if (in_dquote_q) push_beat(8'h00, 1'b0, WARN_NL_DQUOTE, line_q);
        skip_blank_q = 1'b1;
        return;
      end
      CHR_DQUOTE: begin
        if (!in_squote_q && !in_comment_q) in_dquote_q = !in_dquote_q;
      end
      CHR_SQUOTE: begin
        if (!in_dquote_q && !in_comment_q) in_squote_q = !in_squote_q;
      end
      default: ;
    endcase
    push_beat(b, 1'b1, w, line_q);
  endtask

  // All beats caused by one input beat; flags swallowed blanks
  task automatic predict_text_step(input logic [7:0] b, input logic eof,
                                   output bit swallowed);
    int first;
    text_beat_t tail;
    first = expected_beats.size();
    swallowed = 1'b0;
    if (eof) begin
      if (skip_blank_q) push_indent();
      if (depth_q > 16'sd0) push_beat(8'h00, 1'b0, WARN_CLOSE_MIS, depth_q);
      else if (depth_q < 16'sd0) push_beat(8'h00, 1'b0, WARN_OPEN_MIS, -depth_q);
      clear_text_state();
    end else if (skip_blank_q && is_blank(b)) begin
      if (b == CHR_NL) begin
        push_beat(CHR_NL, 1'b1, WARN_NONE, '0);
        bump_line();
      end else begin
        swallowed = 1'b1;
      end
    end else begin
      if (skip_blank_q) begin
        // the byte that ends skipping is its own prior byte
        push_indent();
        skip_blank_q = 1'b0;
        prev_byte_q = b;
      end
      track_byte(b);
    end
    if (expected_beats.size() > first) begin
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  task automatic send_item(input logic [7:0] b, input logic eof);
    bit swallowed;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predict_text_step(b, eof, swallowed);
    if (!swallowed) text_items_sent++;
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    text_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        $error("out beat with nothing expected: byte %0h warning %0d", out_byte_o,
               warning_o);
      end else begin
        want = expected_beats.pop_front();
        check_field("out_byte", want.ch, out_byte_o);
        check_field("byte_valid", want.ch_valid, byte_valid_o);
        check_field("warning", want.warn, warning_o);
        check_field("warn_value", want.warn_val, warn_value_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Byte extremes, then end of file at depth zero: no beat
  task automatic test_field_extremes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // Overlapping marks: the text opens and closes a comment three times, no nested warning
  task automatic test_comments();
    send_text("/*/**/*/");
  endtask

  // Newlines inside single and double quotes; quote ends the skipping
  task automatic test_quotes();
    send_text("'\n'\"\n\"");
  endtask

  // Stray close, repeated newlines, indent at negative depth, eof warnings
  task automatic test_stray_close();
    send_text("))\n\n x");
    send_eof();
    send_text("(\n");
    send_eof();
  endtask

  // Lisp-like text with random content, plus some noise
  task automatic test_random_text(input int n_items);
    int start;
    int pick;
    logic [7:0] q;
    logic [7:0] c;
    start = text_items_sent;
    while (text_items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        repeat ($urandom_range(1, 4)) send_item(CHR_LOWER_A + 8'($urandom_range(25)), 1'b0);
      end else if (pick < 38) begin
        send_item(CHR_LPAREN, 1'b0);
      end else if (pick < 41) begin
        repeat ($urandom_range(4, 10)) send_item(CHR_LPAREN, 1'b0);
      end else if (pick < 52) begin
        send_item(CHR_RPAREN, 1'b0);
      end else if (pick < 64) begin
        // newline followed by a run of blanks
        send_item(CHR_NL, 1'b0);
        repeat ($urandom_range(0, 3)) begin
          c = $urandom_range(1) ? CHR_SPACE : CHR_TAB + 8'($urandom_range(4));
          send_item(c, 1'b0);
        end
      end else if (pick < 72) begin
        q = $urandom_range(1) ? CHR_DQUOTE : CHR_SQUOTE;
        send_item(q, 1'b0);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(4))
            0: c = CHR_NL;
            1: c = $urandom_range(1) ? CHR_LPAREN : CHR_RPAREN;
            2: c = $urandom_range(1) ? CHR_DQUOTE : CHR_SQUOTE;
            default: c = CHR_LOWER_A + 8'($urandom_range(25));
          endcase
          send_item(c, 1'b0);
        end
        send_item(q, 1'b0);
      end else if (pick < 78) begin
        send_text("/*");
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(4))
            0: c = CHR_SLASH;
            1: c = CHR_STAR;
            2: c = $urandom_range(1) ? CHR_DQUOTE : CHR_SQUOTE;
            default: c = CHR_LOWER_A + 8'($urandom_range(25));
          endcase
          send_item(c, 1'b0);
        end
        send_text("*/");
      end else if (pick < 86) begin
        send_item($urandom_range(1) ? CHR_SPACE : CHR_TAB, 1'b0);
      end else if (pick < 97) begin
        send_item(8'($urandom_range(255)), 1'b0);
      end else begin
        send_eof();
      end
    end
    send_eof();
  endtask

  // Depth beyond the cap; eof while skipping gives the full 64 beats
  task automatic test_indent_cap();
    repeat (INDENT_LEVELS + 9) send_item(CHR_LPAREN, 1'b0);
    send_item(CHR_NL, 1'b0);
    send_eof();
  endtask

  initial begin
    clear_text_state();
    set_idling(20, 70);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_comments();
    test_quotes();
    test_stray_close();
    test_random_text(45);

    set_idling(70, 20);
    test_random_text(45);

    set_idling(0, 0);
    test_random_text(45);
    test_indent_cap();

    // drain
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
